### hdl/via_teardrop_points_defines.svh
// Assertion macros shared by the teardrop point checkers
`ifndef VIA_TEARDROP_POINTS_DEFINES_SVH
`define VIA_TEARDROP_POINTS_DEFINES_SVH

// Same-cycle implication, off during reset
`define VTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("teardrop point check failed");

// Next-cycle implication, off during reset
`define VTP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("teardrop point check failed");

// Next-cycle implication that also covers the reset cycles
`define VTP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("teardrop point reset check failed");

`endif

### hdl/vtp_pkg.sv
// Shared constants, types and the arctangent table for the teardrop point block
`timescale 1ns / 1ps
package vtp_pkg;

    localparam int COORD_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POINT_SLOTS      = 6;
    localparam int CFG_BITS         = 31;
    localparam int IDX_BITS         = 3;
    localparam int SLOT_BITS        = 3;
    localparam int ANG_BITS         = 16;
    localparam int ZW               = 18;
    localparam int LEN_FRAC         = 4;
    localparam int GAP_FRAC         = 3;
    localparam int RW_BITS          = 40;
    localparam int GAIN_BITS        = 21;
    localparam int VEC_SHIFT        = 20;
    localparam int ROT_SHIFT        = VEC_SHIFT + LEN_FRAC;

    localparam logic [GAIN_BITS-1:0] GAIN_Q20     = 21'd636751;
    localparam logic [ANG_BITS-1:0]  QUARTER_TURN = 16'd16384;
    localparam logic [ANG_BITS-1:0]  HALF_TURN    = 16'd32768;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST    = 3'(POINT_SLOTS - 1);

    localparam logic [CFG_BITS-1:0] RST_VIA_SIZE  = 31'd600000;
    localparam logic [CFG_BITS-1:0] RST_VIA_DIAM  = 31'd400000;
    localparam logic [CFG_BITS-1:0] RST_TD_LEN    = 31'd500000;
    localparam logic                RST_NEW_STYLE = 1'b1;
    localparam logic                RST_ROUNDED   = 1'b0;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_VIA_SIZE  = 3'd0,
        CFG_VIA_DIAM  = 3'd1,
        CFG_TD_LEN    = 3'd2,
        CFG_NEW_STYLE = 3'd3,
        CFG_ROUNDED   = 3'd4
    } t_cfg_reg;

    // atan(2^-i) in units of a 65536 step full turn
    function automatic logic [ANG_BITS-1:0] atan_unit(input int i);
        logic [ANG_BITS-1:0] v;
        case (i)
            0:       v = 16'd8192;
            1:       v = 16'd4836;
            2:       v = 16'd2555;
            3:       v = 16'd1297;
            4:       v = 16'd651;
            5:       v = 16'd326;
            6:       v = 16'd163;
            7:       v = 16'd81;
            8:       v = 16'd41;
            9:       v = 16'd20;
            10:      v = 16'd10;
            11:      v = 16'd5;
            12:      v = 16'd3;
            13:      v = 16'd1;
            14:      v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/vtp_ifs.sv
// Channel interfaces: input word, result word and register write
`timescale 1ns / 1ps
interface vtp_in_if #(parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF);
    logic                            valid;
    logic                            ready;
    logic signed [COORD_BITS-1:0]    first_x;
    logic signed [COORD_BITS-1:0]    first_y;
    logic signed [COORD_BITS-1:0]    corner_x;
    logic signed [COORD_BITS-1:0]    corner_y;
    logic signed [COORD_BITS-1:0]    second_x;
    logic signed [COORD_BITS-1:0]    second_y;
    logic [vtp_pkg::CFG_BITS-1:0]    first_width;
    logic [vtp_pkg::CFG_BITS-1:0]    second_width;

    modport source (output valid, first_x, first_y, corner_x, corner_y, second_x, second_y,
                    first_width, second_width, input ready);
    modport sink   (input valid, first_x, first_y, corner_x, corner_y, second_x, second_y,
                    first_width, second_width, output ready);
endinterface

interface vtp_out_if #(parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF);
    logic                            valid;
    logic                            ready;
    logic [vtp_pkg::SLOT_BITS-1:0]   point_index;
    logic signed [COORD_BITS-1:0]    point_x;
    logic signed [COORD_BITS-1:0]    point_y;
    logic                            point_present;
    logic                            rejected;
    logic                            last_point;

    modport source (output valid, point_index, point_x, point_y, point_present, rejected,
                    last_point, input ready);
    modport sink   (input valid, point_index, point_x, point_y, point_present, rejected,
                    last_point, output ready);
endinterface

interface vtp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vtp_pkg::IDX_BITS-1:0]    reg_idx;
    logic [vtp_pkg::CFG_BITS-1:0]    wdata;

    modport source (output valid, reg_idx, wdata, input ready);
    modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

### hdl/via_teardrop_points.sv
// Teardrop outline points around a via: top level with track pipelines and output serializer
// Six result words per input word; the six-slot output shift register
// drains one word a cycle while the sink is ready; new results load as the last slot leaves.
// The core pipeline takes a word per cycle and stalls as a whole when the output side is full.
// Reset (synchronous, active low) clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module via_teardrop_points #(
    parameter int COORD_BITS   = vtp_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = vtp_pkg::CORDIC_STEPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vtp_in_if.sink    i_pt,
    vtp_out_if.source o_pt,
    vtp_cfg_if.sink   i_cfg
);
    import vtp_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int VW   = CB + 8;
    localparam int RW   = RW_BITS;
    localparam int CMPW = ((VW > RW) ? VW : RW) + 2;
    localparam int SW   = ((CB > RW) ? CB : RW) + 2;
    localparam int SB1  = 2 * CB + CFG_BITS;
    localparam int SB2  = 2 * CB + 2 * RW + 1 + ANG_BITS;
    localparam int SB3  = 2 * CB + 1;
    localparam logic signed [SW-1:0] C_MAX = (SW'(1) <<< (CB - 1)) - SW'(1);
    localparam logic signed [SW-1:0] C_MIN = -C_MAX - SW'(1);

    // Configuration registers
    logic [CFG_BITS-1:0] r_via_size;
    logic [CFG_BITS-1:0] r_via_diam;
    logic [CFG_BITS-1:0] r_td_len;
    logic                r_new_style;
    logic                r_rounded;

    logic w_en;
    logic w_ob_free;
    logic w_rej;
    logic w_take;

    logic                   r_b_vld;
    logic signed [CB-1:0]   w_far_x [0:1];
    logic signed [CB-1:0]   w_far_y [0:1];
    logic [CFG_BITS-1:0]    w_trk_w [0:1];
    logic                   w_rt_vld [0:1];

    logic                   r_h_vld;
    logic signed [CB-1:0]   r_h_px [0:1][0:2];
    logic signed [CB-1:0]   r_h_py [0:1][0:2];
    logic                   r_h_ok [0:1];

    logic                   r_ob_vld;
    logic [SLOT_BITS-1:0]   r_ob_idx;
    logic                   r_ob_rej;
    logic signed [CB-1:0]   r_ob_x [0:POINT_SLOTS-1];
    logic signed [CB-1:0]   r_ob_y [0:POINT_SLOTS-1];
    logic                   r_ob_p [0:POINT_SLOTS-1];
    logic signed [CB-1:0]   w_ld_x [0:POINT_SLOTS-1];
    logic signed [CB-1:0]   w_ld_y [0:POINT_SLOTS-1];
    logic                   w_ld_p [0:POINT_SLOTS-1];

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_via_size  <= RST_VIA_SIZE;
            r_via_diam  <= RST_VIA_DIAM;
            r_td_len    <= RST_TD_LEN;
            r_new_style <= RST_NEW_STYLE;
            r_rounded   <= RST_ROUNDED;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_idx)
                CFG_VIA_SIZE:  r_via_size  <= i_cfg.wdata;
                CFG_VIA_DIAM:  r_via_diam  <= i_cfg.wdata;
                CFG_TD_LEN:    r_td_len    <= i_cfg.wdata;
                CFG_NEW_STYLE: r_new_style <= i_cfg.wdata[0];
                CFG_ROUNDED:   r_rounded   <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    assign w_rej = r_via_diam > r_via_size;

    // Pipeline advance: stall everything while the tail word cannot move on
    assign w_take    = o_pt.valid && o_pt.ready;
    assign w_ob_free = !r_ob_vld || (o_pt.ready && (r_ob_idx == SLOT_LAST));
    assign w_en      = !r_h_vld || w_ob_free;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= i_pt.valid;
        end
    end

    assign w_far_x[0] = i_pt.first_x;
    assign w_far_y[0] = i_pt.first_y;
    assign w_trk_w[0] = i_pt.first_width;
    assign w_far_x[1] = i_pt.second_x;
    assign w_far_y[1] = i_pt.second_y;
    assign w_trk_w[1] = i_pt.second_width;

    // One lane per track: direction, clip, flank correction, three placements
    for (genvar t = 0; t < 2; t++) begin : g_trk
        logic signed [CB:0]       w_dx;
        logic signed [CB:0]       w_dy;
        logic signed [VW-1:0]     r_b_x;
        logic signed [VW-1:0]     r_b_y;
        logic [SB1-1:0]           r_b_sb;

        logic                     w_v1_vld;
        logic signed [VW-1:0]     w_v1_len;
        logic [ANG_BITS-1:0]      w_v1_ang;
        logic [SB1-1:0]           w_v1_sb;
        logic signed [CB-1:0]     w_v1_cx;
        logic signed [CB-1:0]     w_v1_cy;
        logic [CFG_BITS-1:0]      w_v1_w;

        logic [CMPW-1:0]          w_len_e;
        logic [CMPW-1:0]          w_tl_e;
        logic [CMPW-1:0]          w_dv8_e;
        logic [CMPW-1:0]          w_lv_e;
        logic                     w_ok;
        logic signed [CFG_BITS+1:0] w_gd;

        logic                     r_d_vld;
        logic signed [RW-1:0]     r_d_lv;
        logic signed [RW-1:0]     r_d_gap;
        logic signed [RW-1:0]     r_d_rt;
        logic                     r_d_ok;
        logic [ANG_BITS-1:0]      r_d_ang;
        logic signed [CB-1:0]     r_d_cx;
        logic signed [CB-1:0]     r_d_cy;

        logic                     w_v2_vld;
        logic [ANG_BITS-1:0]      w_v2_corr;
        logic [SB2-1:0]           w_v2_sb;
        logic signed [CB-1:0]     w_v2_cx;
        logic signed [CB-1:0]     w_v2_cy;
        logic signed [RW-1:0]     w_v2_rt;
        logic signed [RW-1:0]     w_v2_gap;
        logic                     w_v2_ok;
        logic [ANG_BITS-1:0]      w_v2_ang;
        logic [ANG_BITS-1:0]      w_an1;

        logic                     r_f_vld;
        logic [ANG_BITS-1:0]      r_f_an0;
        logic [ANG_BITS-1:0]      r_f_an1;
        logic [ANG_BITS-1:0]      r_f_an2;
        logic signed [RW-1:0]     r_f_rt;
        logic signed [RW-1:0]     r_f_gap;
        logic                     r_f_ok;
        logic signed [CB-1:0]     r_f_cx;
        logic signed [CB-1:0]     r_f_cy;

        logic signed [RW-1:0]     w_r_dx [0:2];
        logic signed [RW-1:0]     w_r_dy [0:2];
        logic [SB3-1:0]           w_r_sb;
        logic signed [CB-1:0]     w_r_cx;
        logic signed [CB-1:0]     w_r_cy;
        logic                     w_r_ok;

        // Offset from the corner, scaled to sixteenths of a nanometre
        assign w_dx = {w_far_x[t][CB-1], w_far_x[t]} - {i_pt.corner_x[CB-1], i_pt.corner_x};
        assign w_dy = {w_far_y[t][CB-1], w_far_y[t]} - {i_pt.corner_y[CB-1], i_pt.corner_y};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_b_x  <= VW'(w_dx) <<< LEN_FRAC;
                r_b_y  <= VW'(w_dy) <<< LEN_FRAC;
                r_b_sb <= {i_pt.corner_x, i_pt.corner_y, w_trk_w[t]};
            end
        end

        vtp_cordic #(
            .W(VW), .STEPS(CORDIC_STEPS), .VEC(1'b1), .SHIFT(VEC_SHIFT), .SB_W(SB1)
        ) u_dir (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_b_vld),
            .i_x(r_b_x), .i_y(r_b_y), .i_z('0), .i_sb(r_b_sb),
            .o_vld(w_v1_vld), .o_x(w_v1_len), .o_y(), .o_z(w_v1_ang), .o_sb(w_v1_sb)
        );

        assign {w_v1_cx, w_v1_cy, w_v1_w} = w_v1_sb;

        // Length tests and clip of the teardrop length
        assign w_len_e = CMPW'(w_v1_len[VW-2:0]);
        assign w_tl_e  = CMPW'({r_td_len, LEN_FRAC'(0)});
        assign w_dv8_e = CMPW'({r_via_diam, GAP_FRAC'(0)});
        assign w_gd    = $signed({2'b00, r_via_diam}) - $signed({2'b00, w_v1_w});

        always_comb begin
            if (r_rounded) begin
                w_lv_e = (w_len_e < (w_tl_e << 1)) ? (w_len_e >> 1) : w_tl_e;
            end else begin
                w_lv_e = (w_len_e < w_tl_e) ? w_len_e : w_tl_e;
            end
            w_ok = (w_len_e >= w_dv8_e) && !w_rej;
            if (r_new_style && (w_lv_e < w_dv8_e)) begin
                w_ok = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld <= 1'b0;
            end else if (w_en) begin
                r_d_vld <= w_v1_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d_lv  <= RW'(w_lv_e);
                r_d_gap <= RW'(w_gd) <<< GAP_FRAC;
                r_d_rt  <= r_new_style ? RW'(w_lv_e) : RW'(w_tl_e);
                r_d_ok  <= w_ok;
                r_d_ang <= w_v1_ang;
                r_d_cx  <= w_v1_cx;
                r_d_cy  <= w_v1_cy;
            end
        end

        vtp_cordic #(
            .W(RW), .STEPS(CORDIC_STEPS), .VEC(1'b1), .SHIFT(VEC_SHIFT), .SB_W(SB2)
        ) u_corr (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_d_vld),
            .i_x(r_d_lv), .i_y(r_d_gap), .i_z('0),
            .i_sb({r_d_cx, r_d_cy, r_d_rt, r_d_gap, r_d_ok, r_d_ang}),
            .o_vld(w_v2_vld), .o_x(), .o_y(), .o_z(w_v2_corr), .o_sb(w_v2_sb)
        );

        assign {w_v2_cx, w_v2_cy, w_v2_rt, w_v2_gap, w_v2_ok, w_v2_ang} = w_v2_sb;

        // Flank angles: quarter turn less the correction, then mirrored
        assign w_an1 = w_v2_ang + QUARTER_TURN - w_v2_corr;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_f_vld <= 1'b0;
            end else if (w_en) begin
                r_f_vld <= w_v2_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_f_an0 <= w_v2_ang;
                r_f_an1 <= w_an1;
                r_f_an2 <= w_an1 + HALF_TURN + (w_v2_corr << 1);
                r_f_rt  <= w_v2_rt;
                r_f_gap <= w_v2_gap;
                r_f_ok  <= w_v2_ok;
                r_f_cx  <= w_v2_cx;
                r_f_cy  <= w_v2_cy;
            end
        end

        vtp_cordic #(
            .W(RW), .STEPS(CORDIC_STEPS), .VEC(1'b0), .SHIFT(ROT_SHIFT), .SB_W(SB3)
        ) u_tip (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_f_vld),
            .i_x(r_f_rt), .i_y('0), .i_z(r_f_an0), .i_sb({r_f_cx, r_f_cy, r_f_ok}),
            .o_vld(w_rt_vld[t]), .o_x(w_r_dx[0]), .o_y(w_r_dy[0]), .o_z(), .o_sb(w_r_sb)
        );

        vtp_cordic #(
            .W(RW), .STEPS(CORDIC_STEPS), .VEC(1'b0), .SHIFT(ROT_SHIFT), .SB_W(1)
        ) u_flank_a (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_f_vld),
            .i_x(r_f_gap), .i_y('0), .i_z(r_f_an1), .i_sb(1'b0),
            .o_vld(), .o_x(w_r_dx[1]), .o_y(w_r_dy[1]), .o_z(), .o_sb()
        );

        vtp_cordic #(
            .W(RW), .STEPS(CORDIC_STEPS), .VEC(1'b0), .SHIFT(ROT_SHIFT), .SB_W(1)
        ) u_flank_b (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_f_vld),
            .i_x(r_f_gap), .i_y('0), .i_z(r_f_an2), .i_sb(1'b0),
            .o_vld(), .o_x(w_r_dx[2]), .o_y(w_r_dy[2]), .o_z(), .o_sb()
        );

        assign {w_r_cx, w_r_cy, w_r_ok} = w_r_sb;

        // Add the corner and saturate
        for (genvar j = 0; j < 3; j++) begin : g_pt
            logic signed [SW-1:0] w_sx;
            logic signed [SW-1:0] w_sy;

            assign w_sx = SW'(w_r_cx) + SW'(w_r_dx[j]);
            assign w_sy = SW'(w_r_cy) + SW'(w_r_dy[j]);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_h_px[t][j] <= (w_sx > C_MAX) ? CB'(C_MAX) :
                                    (w_sx < C_MIN) ? CB'(C_MIN) : CB'(w_sx);
                    r_h_py[t][j] <= (w_sy > C_MAX) ? CB'(C_MAX) :
                                    (w_sy < C_MIN) ? CB'(C_MIN) : CB'(w_sy);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_h_ok[t] <= w_r_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_h_vld <= w_rt_vld[0] && w_rt_vld[1];
        end
    end

    // Map track points to output slots; absent slots read as zero
    always_comb begin
        for (int s = 0; s < POINT_SLOTS; s++) begin
            w_ld_x[s] = '0;
            w_ld_y[s] = '0;
            w_ld_p[s] = 1'b0;
        end
        if (r_new_style) begin
            for (int j = 0; j < 3; j++) begin
                w_ld_p[j]     = r_h_ok[1];
                w_ld_x[j]     = r_h_ok[1] ? r_h_px[1][j] : '0;
                w_ld_y[j]     = r_h_ok[1] ? r_h_py[1][j] : '0;
                w_ld_p[j + 3] = r_h_ok[0];
                w_ld_x[j + 3] = r_h_ok[0] ? r_h_px[0][j] : '0;
                w_ld_y[j + 3] = r_h_ok[0] ? r_h_py[0][j] : '0;
            end
        end else begin
            w_ld_p[0] = r_h_ok[1];
            w_ld_x[0] = r_h_ok[1] ? r_h_px[1][0] : '0;
            w_ld_y[0] = r_h_ok[1] ? r_h_py[1][0] : '0;
            w_ld_p[1] = r_h_ok[0];
            w_ld_x[1] = r_h_ok[0] ? r_h_px[0][0] : '0;
            w_ld_y[1] = r_h_ok[0] ? r_h_py[0][0] : '0;
        end
    end

    // Output shift register: load six slots, shift one out per taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_vld <= 1'b0;
            r_ob_idx <= '0;
        end else if (w_en && r_h_vld) begin
            r_ob_vld <= 1'b1;
            r_ob_idx <= '0;
        end else if (w_take) begin
            r_ob_vld <= (r_ob_idx != SLOT_LAST);
            r_ob_idx <= r_ob_idx + SLOT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_h_vld) begin
            r_ob_rej <= w_rej;
            for (int s = 0; s < POINT_SLOTS; s++) begin
                r_ob_x[s] <= w_ld_x[s];
                r_ob_y[s] <= w_ld_y[s];
                r_ob_p[s] <= w_ld_p[s];
            end
        end else if (w_take) begin
            for (int s = 0; s < POINT_SLOTS - 1; s++) begin
                r_ob_x[s] <= r_ob_x[s + 1];
                r_ob_y[s] <= r_ob_y[s + 1];
                r_ob_p[s] <= r_ob_p[s + 1];
            end
        end
    end

    assign o_pt.valid         = r_ob_vld;
    assign o_pt.point_index   = r_ob_idx;
    assign o_pt.point_x       = r_ob_x[0];
    assign o_pt.point_y       = r_ob_y[0];
    assign o_pt.point_present = r_ob_p[0];
    assign o_pt.rejected      = r_ob_rej;
    assign o_pt.last_point    = (r_ob_idx == SLOT_LAST);

endmodule

### hdl/vtp_cordic.sv
// Pipelined CORDIC, vectoring or rotation, one iteration per stage, gain-corrected output
`timescale 1ns / 1ps
module vtp_cordic #(
    parameter int W     = vtp_pkg::RW_BITS,
    parameter int STEPS = vtp_pkg::CORDIC_STEPS_DEF,
    parameter bit VEC   = 1'b1,
    parameter int SHIFT = vtp_pkg::VEC_SHIFT,
    parameter int SB_W  = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic [vtp_pkg::ANG_BITS-1:0]  i_z,
    input  logic [SB_W-1:0]               i_sb,
    output logic                          o_vld,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic [vtp_pkg::ANG_BITS-1:0]  o_z,
    output logic [SB_W-1:0]               o_sb
);
    import vtp_pkg::*;

    localparam int PW = W + GAIN_BITS;
    localparam logic signed [ZW-1:0] Z_QTR  = ZW'(QUARTER_TURN);
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(HALF_TURN);
    localparam logic signed [PW-1:0] GAIN   = PW'(GAIN_Q20);
    localparam logic signed [PW-1:0] RND    = PW'(1) <<< (SHIFT - 1);

    logic                   r_vld  [0:STEPS];
    logic signed [W-1:0]    r_x    [0:STEPS];
    logic signed [W-1:0]    r_y    [0:STEPS];
    logic signed [ZW-1:0]   r_z    [0:STEPS];
    logic                   r_zero [0:STEPS];
    logic [SB_W-1:0]        r_sb   [0:STEPS];

    logic signed [W-1:0]    n_x0;
    logic signed [W-1:0]    n_y0;
    logic signed [ZW-1:0]   n_z0;
    logic                   n_zero0;
    logic signed [ZW-1:0]   w_zs;

    logic                   r_m_vld;
    logic signed [PW-1:0]   r_m_x;
    logic signed [PW-1:0]   r_m_y;
    logic [ANG_BITS-1:0]    r_m_z;
    logic [SB_W-1:0]        r_m_sb;
    logic                   r_o_vld;

    // Pre-stage: fold the input into the convergence range
    always_comb begin
        n_x0    = i_x;
        n_y0    = i_y;
        n_zero0 = 1'b0;
        w_zs    = ZW'($signed(i_z));
        if (VEC) begin
            n_z0    = $signed(ZW'(i_z));
            n_zero0 = (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                n_x0 = -i_x;
                n_y0 = -i_y;
                n_z0 = $signed(ZW'(i_z)) + Z_HALF;
            end
        end else begin
            n_z0 = w_zs;
            if (w_zs > Z_QTR) begin
                n_z0 = w_zs - Z_HALF;
                n_x0 = -i_x;
                n_y0 = -i_y;
            end else if (w_zs < -Z_QTR) begin
                n_z0 = w_zs + Z_HALF;
                n_x0 = -i_x;
                n_y0 = -i_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= n_zero0;
            r_sb[0]   <= i_sb;
        end
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic signed [ZW-1:0] AT = ZW'(atan_unit(k));
        logic w_neg;
        logic signed [W-1:0] w_xs;
        logic signed [W-1:0] w_ys;

        assign w_neg = VEC ? (r_y[k] > 0) : (r_z[k] < 0);
        assign w_xs  = r_x[k] >>> k;
        assign w_ys  = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_neg) begin
                    r_x[k+1] <= r_x[k] + w_ys;
                    r_y[k+1] <= r_y[k] - w_xs;
                    r_z[k+1] <= r_z[k] + AT;
                end else begin
                    r_x[k+1] <= r_x[k] - w_ys;
                    r_y[k+1] <= r_y[k] + w_xs;
                    r_z[k+1] <= r_z[k] - AT;
                end
                r_zero[k+1] <= r_zero[k];
                r_sb[k+1]   <= r_sb[k];
            end
        end
    end

    // Gain correction: multiply, then round and scale down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_m_vld <= r_vld[STEPS];
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_x  <= PW'(r_x[STEPS]) * GAIN;
            r_m_y  <= PW'(r_y[STEPS]) * GAIN;
            r_m_z  <= r_zero[STEPS] ? '0 : r_z[STEPS][ANG_BITS-1:0];
            r_m_sb <= r_sb[STEPS];
            o_x    <= W'((r_m_x + RND) >>> SHIFT);
            o_y    <= W'((r_m_y + RND) >>> SHIFT);
            o_z    <= r_m_z;
            o_sb   <= r_m_sb;
        end
    end

    assign o_vld = r_o_vld;

endmodule

### hdl/vtp_checker.sv
// Port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
`include "via_teardrop_points_defines.svh"
module vtp_checker #(
    parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [vtp_pkg::SLOT_BITS-1:0]  i_point_index,
    input logic signed [COORD_BITS-1:0]   i_point_x,
    input logic signed [COORD_BITS-1:0]   i_point_y,
    input logic                           i_point_present,
    input logic                           i_rejected,
    input logic                           i_last_point
);
    import vtp_pkg::*;

    // A stalled word holds
    `VTP_ASSERT_NXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_point_x) && $stable(i_point_y) && $stable(i_point_index))
    // Last flag marks the final slot only
    `VTP_ASSERT_IMP(a_last, i_out_valid, i_last_point == (i_point_index == SLOT_LAST))
    // Absent or rejected slots read as zero
    `VTP_ASSERT_IMP(a_zero, i_out_valid && (!i_point_present || i_rejected), !i_point_present && i_point_x == '0 && i_point_y == '0)
    // Nothing leaves right after reset
    `VTP_ASSERT_RST(a_rst, !i_rst_n, !i_out_valid)

endmodule

bind via_teardrop_points vtp_checker #(.COORD_BITS(COORD_BITS)) u_vtp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_pt.valid),
    .i_out_ready    (o_pt.ready),
    .i_point_index  (o_pt.point_index),
    .i_point_x      (o_pt.point_x),
    .i_point_y      (o_pt.point_y),
    .i_point_present(o_pt.point_present),
    .i_rejected     (o_pt.rejected),
    .i_last_point   (o_pt.last_point)
);
